// ===== design/sha224_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sha224_pkg
// shared constants, types and round functions of the sha-224 compressor
// ---------------------------------------------------------------------------
package sha224_pkg;

  localparam int WordW      = 32;
  localparam int BlockWords = 16;
  localparam int Rounds     = 64;
  localparam int DigestWords = 7;
  localparam int QueueDepth = 4;

  // one block handed from front to back
  typedef struct packed {
    logic [BlockWords*WordW-1:0] words;  // word 0 in lowest bits
    logic                        restart;
    logic                        final_blk;
  } blk_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } back_state_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    unique case (t)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h;
    unique case (i)
      3'd0: h = 32'hc1059ed8; 3'd1: h = 32'h367cd507;
      3'd2: h = 32'h3070dd17; 3'd3: h = 32'hf70e5939;
      3'd4: h = 32'hffc00b31; 3'd5: h = 32'h68581511;
      3'd6: h = 32'h64f98fa7; default: h = 32'hbefa4fa4;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] v);
    return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction
  function automatic logic [31:0] bsig1(input logic [31:0] v);
    return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction
  function automatic logic [31:0] ssig0(input logic [31:0] v);
    return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction
  function automatic logic [31:0] ssig1(input logic [31:0] v);
    return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

endpackage
`default_nettype wire

// ===== design/sha224_block_compressor.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sha224_block_compressor
// sha-224 compression of pre-padded 512-bit blocks, digest as seven words
// ---------------------------------------------------------------------------
// Words are taken one per cycle; only a block's last word needs queue room.
// Each sixteen words form a block queued for the round engine, which runs
// one round per cycle: it loads a block, runs 64 rounds and the add, then
// emits seven digest words after a final block; it takes no new block until
// then. The queue holds Depth blocks, so input keeps flowing while a block
// is compressed. Padding and length fields must be supplied upstream.
module sha224_block_compressor #(
  parameter int Depth = sha224_pkg::QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // message_word
  input  wire logic [1:0]  in_tuser,   // start_message, final_block
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // digest_word, word_number, zero pad
  output logic             out_tlast
);

  logic             f_valid, f_ready, q_valid, q_ready;
  sha224_pkg::blk_t f_data, q_data;
  logic [31:0]      dword;
  logic [2:0]       dnum;

  sha224_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .in_word(in_tdata), .in_start(in_tuser[0]), .in_final(in_tuser[1]),
    .blk_valid(f_valid), .blk_ready(f_ready), .blk_data(f_data)
  );

  sha224_queue #(.Depth(Depth)) u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  sha224_engine u_engine (
    .clk, .rst_n,
    .blk_valid(q_valid), .blk_ready(q_ready), .blk_data(q_data),
    .out_tvalid, .out_tready,
    .out_word(dword), .out_num(dnum), .out_last(out_tlast)
  );

  assign out_tdata = {5'd0, dnum, dword};

endmodule
`default_nettype wire

// ===== design/sha224_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sha224_front
// collects message words into blocks, tracks start and final flags
// ---------------------------------------------------------------------------
module sha224_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [31:0]        in_word,
  input  wire logic               in_start,
  input  wire logic               in_final,
  output logic                    blk_valid,
  input  wire logic               blk_ready,
  output sha224_pkg::blk_t        blk_data
);

  logic [3:0]  pos_r, pos_nxt;
  logic        fin_r, fin_nxt;
  logic        rst_blk_r, rst_blk_nxt;
  logic [31:0] buf_r [sha224_pkg::BlockWords];
  logic        take;
  logic [3:0]  wpos;
  logic        last_word;

  assign wpos      = in_start ? 4'd0 : pos_r;
  assign last_word = (wpos == 4'(sha224_pkg::BlockWords - 1));
  // only the closing word needs room in the queue
  assign in_tready = !last_word || blk_ready;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    blk_valid = in_tvalid && last_word;
    for (int i = 0; i < sha224_pkg::BlockWords; i++) begin
      blk_data.words[i*32 +: 32] = (i == sha224_pkg::BlockWords - 1) ? in_word : buf_r[i];
    end
    blk_data.restart   = rst_blk_r || in_start;
    blk_data.final_blk = (fin_r && !in_start) || in_final;
  end

  always_comb begin
    pos_nxt     = pos_r;
    fin_nxt     = fin_r;
    rst_blk_nxt = rst_blk_r;
    if (take) begin
      if (last_word) begin
        pos_nxt     = 4'd0;
        fin_nxt     = 1'b0;
        rst_blk_nxt = 1'b0;
      end else begin
        pos_nxt     = wpos + 4'd1;
        fin_nxt     = (fin_r && !in_start) || in_final;
        rst_blk_nxt = rst_blk_r || in_start;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 4'd0;
      fin_r     <= 1'b0;
      rst_blk_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      fin_r     <= fin_nxt;
      rst_blk_r <= rst_blk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      buf_r[wpos] <= in_word;
    end
  end

endmodule
`default_nettype wire

// ===== design/sha224_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sha224_queue
// small block fifo between word collection and the round engine
// ---------------------------------------------------------------------------
module sha224_queue #(
  parameter int Depth = sha224_pkg::QueueDepth
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_valid,
  output logic                    wr_ready,
  input  wire sha224_pkg::blk_t   wr_data,
  output logic                    rd_valid,
  input  wire logic               rd_ready,
  output sha224_pkg::blk_t        rd_data
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  sha224_pkg::blk_t mem_r [Depth];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          wr, rd;

  assign wr_ready = (cnt_r != (AW+1)'(Depth));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr) wp_nxt = (wp_r == AW'(Depth - 1)) ? '0 : wp_r + 1'b1;
    if (rd) rp_nxt = (rp_r == AW'(Depth - 1)) ? '0 : rp_r + 1'b1;
    if (wr && !rd) cnt_nxt = cnt_r + 1'b1;
    else if (rd && !wr) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

endmodule
`default_nettype wire

// ===== design/sha224_engine.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sha224_engine
// one round per cycle compression, chaining update and digest output
// ---------------------------------------------------------------------------
module sha224_engine (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               blk_valid,
  output logic                    blk_ready,
  input  wire sha224_pkg::blk_t   blk_data,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [31:0]             out_word,
  output logic [2:0]              out_num,
  output logic                    out_last
);

  sha224_pkg::back_state_t st_r, st_nxt;
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [sha224_pkg::BlockWords];
  logic [5:0]  t_r;
  logic [2:0]  k_r;
  logic        fin_r;
  logic [31:0] wt, s1, s2, ch, mj;
  logic        load, round_go, add_go, emit_go;

  // schedule window shifts: w_r[0] is always the current word
  always_comb begin
    wt = w_r[0];
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    s1 = v_r[7] + sha224_pkg::bsig1(v_r[4]) + ch + sha224_pkg::round_k(t_r) + wt;
    s2 = sha224_pkg::bsig0(v_r[0]) + mj;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      sha224_pkg::ST_IDLE:  if (blk_valid) st_nxt = sha224_pkg::ST_ROUND;
      sha224_pkg::ST_ROUND: if (t_r == 6'(sha224_pkg::Rounds - 1)) st_nxt = sha224_pkg::ST_ADD;
      sha224_pkg::ST_ADD:   st_nxt = fin_r ? sha224_pkg::ST_EMIT : sha224_pkg::ST_IDLE;
      sha224_pkg::ST_EMIT:
        if (out_tready && k_r == 3'(sha224_pkg::DigestWords - 1)) st_nxt = sha224_pkg::ST_IDLE;
      default: st_nxt = sha224_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    blk_ready  = (st_r == sha224_pkg::ST_IDLE);
    load       = blk_ready && blk_valid;
    round_go   = (st_r == sha224_pkg::ST_ROUND);
    add_go     = (st_r == sha224_pkg::ST_ADD);
    out_tvalid = (st_r == sha224_pkg::ST_EMIT);
    emit_go    = out_tvalid && out_tready;
    out_word   = h_r[k_r];
    out_num    = k_r;
    out_last   = (k_r == 3'(sha224_pkg::DigestWords - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= sha224_pkg::ST_IDLE;
      t_r  <= '0;
      k_r  <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= sha224_pkg::init_h(3'(i));
    end else begin
      st_r <= st_nxt;
      if (load) begin
        t_r <= '0;
        k_r <= '0;
        if (blk_data.restart) begin
          for (int i = 0; i < 8; i++) h_r[i] <= sha224_pkg::init_h(3'(i));
        end
      end
      if (round_go) t_r <= t_r + 6'd1;
      if (add_go) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
      if (emit_go) k_r <= k_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fin_r <= blk_data.final_blk;
      for (int i = 0; i < sha224_pkg::BlockWords; i++) w_r[i] <= blk_data.words[i*32 +: 32];
      for (int i = 0; i < 8; i++) v_r[i] <= blk_data.restart ? sha224_pkg::init_h(3'(i)) : h_r[i];
    end else if (round_go) begin
      for (int i = 0; i < sha224_pkg::BlockWords - 1; i++) w_r[i] <= w_r[i+1];
      w_r[sha224_pkg::BlockWords-1] <= sha224_pkg::ssig1(w_r[14]) + w_r[9]
                                      + sha224_pkg::ssig0(w_r[1]) + w_r[0];
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + s1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= s1 + s2;
    end
  end

endmodule
`default_nettype wire
